@@ rtl/fmfv_pkg.sv @@
`default_nettype none

package fmfv_pkg;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_EMPTY     = 3'd1;
  localparam logic [2:0] ERR_NO_EQUALS = 3'd2;
  localparam logic [2:0] ERR_BAD_TAG   = 3'd3;
  localparam logic [2:0] ERR_MISSING   = 3'd4;
  localparam logic [2:0] ERR_VERSION   = 3'd5;
  localparam logic [2:0] ERR_TYPE      = 3'd6;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd7;

  localparam logic       REG_DELIMITER = 1'b0;
  localparam logic       REG_VERSION   = 1'b1;

  localparam logic [7:0] EQUALS_BYTE   = 8'h3D;
  localparam logic [3:0] CHECKSUM_LEN  = 4'd3;
  localparam logic [3:0] VERSION_LEN   = 4'd7;
  localparam logic [3:0] LEN_CAP       = 4'd8;

  localparam logic [7:0]  DELIMITER_RESET = 8'h01;
  localparam logic [55:0] VERSION_RESET   = 56'h4649582E342E34;

  // tag scan phases
  localparam logic [1:0] PH_SPACE   = 2'd0;
  localparam logic [1:0] PH_SIGN    = 2'd1;
  localparam logic [1:0] PH_DIGITS  = 2'd2;
  localparam logic [1:0] PH_STOPPED = 2'd3;

  typedef struct packed {
    logic [1:0]  phase;
    logic        neg;
    logic [31:0] mag;
    logic        ovf;
  } tag_t;

  localparam tag_t TAG_CLEAR = '{phase: PH_SPACE, neg: 1'b0, mag: 32'd0, ovf: 1'b0};

  function automatic logic tag_is(tag_t t, logic [31:0] v);
    return !t.neg && (t.mag == v);
  endfunction

endpackage

`default_nettype wire

@@ rtl/fmfv_if.sv @@
`default_nettype none

interface fmfv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source(output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink(input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface fmfv_out_if;
  logic       valid;
  logic       ready;
  logic       message_valid;
  logic [2:0] error_code;
  logic [7:0] message_type;

  modport source(output valid, message_valid, error_code, message_type, input ready);
  modport sink(input valid, message_valid, error_code, message_type, output ready);
endinterface

`default_nettype wire

@@ rtl/fmfv_tag_scan.sv @@
`default_nettype none

// strtol-style tag parse, one byte per call
module fmfv_tag_scan
  import fmfv_pkg::*;
(
  input  tag_t       cur,
  input  logic [7:0] data,
  output tag_t       nxt
);

  logic        digit;
  logic        space;
  logic [35:0] next_mag;
  logic [35:0] limit;

  always_comb begin
    digit    = (data >= 8'h30) && (data <= 8'h39);
    space    = (data == 8'h20) || ((data >= 8'h09) && (data <= 8'h0D));
    next_mag = {1'b0, cur.mag, 3'b000} + {3'b000, cur.mag, 1'b0}
             + {32'd0, data[3:0]};
    limit    = cur.neg ? 36'h080000000 : 36'h07FFFFFFF;
    nxt      = cur;
    if (cur.phase != PH_STOPPED) begin
      if (digit) begin
        nxt.phase = PH_DIGITS;
        if (!cur.ovf) begin
          if (next_mag > limit) begin
            nxt.ovf = 1'b1;
          end else begin
            nxt.mag = next_mag[31:0];
          end
        end
      end else if (cur.phase == PH_SPACE && space) begin
        nxt = cur;
      end else if (cur.phase == PH_SPACE && (data == 8'h2B || data == 8'h2D)) begin
        nxt.phase = PH_SIGN;
        nxt.neg   = (data == 8'h2D);
      end else begin
        // stopped before any digit counts as a bad tag
        if (cur.phase != PH_DIGITS) begin
          nxt.ovf = 1'b1;
        end
        nxt.phase = PH_STOPPED;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/fix_message_frame_validator_unit.sv @@
// Verdict path: the end-of-message item is held in the input register, and its verdict is
//   then captured in the result register.
// Throughput: one byte item per cycle, sustained; the input stalls only while a
//   verdict waits in the result register and the next end-of-message item sits in the input register.
// Reset (rst, synchronous): delimiter back to SOH, version back to FIX.4.4,
//   all field and message state cleared, both stages empty.
`default_nettype none

module fix_message_frame_validator_unit
  import fmfv_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  fmfv_in_if.sink       msg,
  fmfv_out_if.source    verdict,
  input  logic          cfg_write,
  input  logic          cfg_index,
  input  logic [55:0]   cfg_data
);

  // configuration
  logic [7:0]  delim_byte;
  logic [55:0] expected_version;

  // input register
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_has;
  logic       s_eom;
  logic       s_adv;

  // field state
  logic       in_value_part, in_value_part_next;
  tag_t       tag, tag_next, tag_scanned;
  logic       field_has_bytes, field_has_bytes_next;
  logic [3:0] value_length_seen, value_length_seen_next;
  logic       version_bytes_match, version_bytes_match_next;
  logic [7:0] first_value_byte, first_value_byte_next;

  // message state
  logic [3:0] header_tags_present, header_tags_present_next;
  logic       version_ok, version_ok_next;
  logic [7:0] type_byte, type_byte_next;
  logic       type_nonempty, type_nonempty_next;
  logic       checksum_length_ok, checksum_length_ok_next;
  logic [2:0] first_error, first_error_next;
  logic       message_has_bytes, message_has_bytes_next;

  // result register
  logic       out_valid;
  logic       out_message_valid;
  logic [2:0] out_error_code;
  logic [7:0] out_message_type;

  logic       close_en;
  logic [7:0] want_byte;
  logic [2:0] code;
  logic [7:0] mtype;

  assign s_adv     = s_valid && (!s_eom || !out_valid || verdict.ready);
  assign msg.ready = !s_valid || s_adv;

  assign verdict.valid         = out_valid;
  assign verdict.message_valid = out_message_valid;
  assign verdict.error_code    = out_error_code;
  assign verdict.message_type  = out_message_type;

  fmfv_tag_scan u_tag_scan (
    .cur  (tag),
    .data (s_byte),
    .nxt  (tag_scanned)
  );

  always_comb begin
    unique case (value_length_seen[2:0])
      3'd0: want_byte = expected_version[55:48];
      3'd1: want_byte = expected_version[47:40];
      3'd2: want_byte = expected_version[39:32];
      3'd3: want_byte = expected_version[31:24];
      3'd4: want_byte = expected_version[23:16];
      3'd5: want_byte = expected_version[15:8];
      3'd6: want_byte = expected_version[7:0];
      3'd7: want_byte = 8'h00;
    endcase
  end

  always_comb begin
    in_value_part_next       = in_value_part;
    tag_next                 = tag;
    field_has_bytes_next     = field_has_bytes;
    value_length_seen_next   = value_length_seen;
    version_bytes_match_next = version_bytes_match;
    first_value_byte_next    = first_value_byte;
    header_tags_present_next = header_tags_present;
    version_ok_next          = version_ok;
    type_byte_next           = type_byte;
    type_nonempty_next       = type_nonempty;
    checksum_length_ok_next  = checksum_length_ok;
    first_error_next         = first_error;
    message_has_bytes_next   = message_has_bytes;
    close_en                 = 1'b0;
    code                     = ERR_NONE;
    mtype                    = 8'h00;

    if (s_has) begin
      message_has_bytes_next = 1'b1;
      if (s_byte == delim_byte) begin
        close_en = 1'b1;
      end else begin
        field_has_bytes_next = 1'b1;
        if (in_value_part) begin
          if (!(value_length_seen < VERSION_LEN && want_byte == s_byte)) begin
            version_bytes_match_next = 1'b0;
          end
          if (value_length_seen == 4'd0) begin
            first_value_byte_next = s_byte;
          end
          if (value_length_seen < LEN_CAP) begin
            value_length_seen_next = value_length_seen + 4'd1;
          end
        end else if (s_byte == EQUALS_BYTE) begin
          in_value_part_next = 1'b1;
          if (first_error == ERR_NONE && (tag.phase < PH_DIGITS || tag.ovf)) begin
            first_error_next = ERR_BAD_TAG;
          end
        end else begin
          tag_next = tag_scanned;
        end
      end
    end

    if (s_eom) begin
      close_en = 1'b1;
    end

    // a delimiter with end mark closes the field once; the second close is a no-op
    if (close_en) begin
      if (field_has_bytes_next && first_error_next == ERR_NONE) begin
        if (!in_value_part_next) begin
          first_error_next = ERR_NO_EQUALS;
        end else if (tag_is(tag_next, 32'd8)) begin
          header_tags_present_next[0] = 1'b1;
          version_ok_next = version_bytes_match_next && (value_length_seen_next == VERSION_LEN);
        end else if (tag_is(tag_next, 32'd9)) begin
          header_tags_present_next[1] = 1'b1;
        end else if (tag_is(tag_next, 32'd35)) begin
          header_tags_present_next[2] = 1'b1;
          type_nonempty_next = (value_length_seen_next != 4'd0);
          type_byte_next     = (value_length_seen_next != 4'd0) ? first_value_byte_next : 8'h00;
        end else if (tag_is(tag_next, 32'd10)) begin
          header_tags_present_next[3] = 1'b1;
          checksum_length_ok_next = (value_length_seen_next == CHECKSUM_LEN);
        end
      end
      in_value_part_next       = 1'b0;
      tag_next                 = TAG_CLEAR;
      field_has_bytes_next     = 1'b0;
      value_length_seen_next   = 4'd0;
      version_bytes_match_next = 1'b1;
      first_value_byte_next    = 8'h00;
    end

    priority if (!message_has_bytes_next) begin
      code = ERR_EMPTY;
    end else if (first_error_next != ERR_NONE) begin
      code = first_error_next;
    end else if (header_tags_present_next != 4'hF) begin
      code = ERR_MISSING;
    end else if (!version_ok_next) begin
      code = ERR_VERSION;
    end else if (!type_nonempty_next) begin
      code = ERR_TYPE;
    end else if (!checksum_length_ok_next) begin
      code = ERR_CHECKSUM;
    end else begin
      code = ERR_NONE;
    end
    if (code == ERR_NONE || code == ERR_CHECKSUM) begin
      mtype = type_byte_next;
    end

    if (s_eom) begin
      header_tags_present_next = 4'h0;
      version_ok_next          = 1'b0;
      type_byte_next           = 8'h00;
      type_nonempty_next       = 1'b0;
      checksum_length_ok_next  = 1'b0;
      first_error_next         = ERR_NONE;
      message_has_bytes_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_byte       <= DELIMITER_RESET;
      expected_version <= VERSION_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELIMITER: delim_byte       <= cfg_data[7:0];
        REG_VERSION:   expected_version <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (msg.ready) begin
      s_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      s_byte <= msg.data_byte;
      s_has  <= msg.has_byte;
      s_eom  <= msg.end_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value_part       <= 1'b0;
      tag                 <= TAG_CLEAR;
      field_has_bytes     <= 1'b0;
      value_length_seen   <= 4'd0;
      version_bytes_match <= 1'b1;
      first_value_byte    <= 8'h00;
      header_tags_present <= 4'h0;
      version_ok          <= 1'b0;
      type_byte           <= 8'h00;
      type_nonempty       <= 1'b0;
      checksum_length_ok  <= 1'b0;
      first_error         <= ERR_NONE;
      message_has_bytes   <= 1'b0;
    end else if (s_adv) begin
      in_value_part       <= in_value_part_next;
      tag                 <= tag_next;
      field_has_bytes     <= field_has_bytes_next;
      value_length_seen   <= value_length_seen_next;
      version_bytes_match <= version_bytes_match_next;
      first_value_byte    <= first_value_byte_next;
      header_tags_present <= header_tags_present_next;
      version_ok          <= version_ok_next;
      type_byte           <= type_byte_next;
      type_nonempty       <= type_nonempty_next;
      checksum_length_ok  <= checksum_length_ok_next;
      first_error         <= first_error_next;
      message_has_bytes   <= message_has_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_adv && s_eom) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv && s_eom) begin
      out_message_valid <= (code == ERR_NONE);
      out_error_code    <= code;
      out_message_type  <= mtype;
    end
  end

  // verdict flag agrees with the code
  a_valid_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_message_valid == (out_error_code == ERR_NONE)))
    else $error("message_valid disagrees with error_code");

  // type byte only reported on pass or checksum-length failure
  a_type_masked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_error_code != ERR_NONE && out_error_code != ERR_CHECKSUM)
      |-> (out_message_type == 8'h00))
    else $error("message_type set for an early failure");

  // message state is clean after each verdict
  a_msg_cleared: assert property (@(posedge clk) disable iff (rst)
    (s_adv && s_eom) |=> (first_error == ERR_NONE && !message_has_bytes
                          && header_tags_present == 4'h0 && !field_has_bytes))
    else $error("message state not cleared after verdict");

  // an end item held back by a full result register stays in the input stage
  a_eom_held: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_eom && out_valid && !verdict.ready) |=> (s_valid && s_eom))
    else $error("end-of-message item lost while result stalled");

  // a new verdict only lands in a free or draining result register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !verdict.ready) |=> (out_valid && $stable(out_error_code)
                                       && $stable(out_message_type)))
    else $error("pending verdict overwritten");

endmodule

`default_nettype wire
